[src/vss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_pkg - shared types and constants of the VFD scan serializer
// Store geometry, command format passed between front and back, anode
// bit map and the brightness to blanking index table.
// ----------------------------------------------------------------------------
package vss_pkg;

    localparam int CHARACTERS       = 40;
    localparam int COLUMNS_PER_CHAR = 5;
    localparam int STORE_DEPTH      = CHARACTERS * COLUMNS_PER_CHAR;

    localparam int ADDR_W   = 8;
    localparam int ROW_W    = 7;
    localparam int BAR_W    = 20;
    localparam int POS_W    = 6;
    localparam int SHIFT_W  = 40;
    localparam int BLANK_W  = 7;
    localparam int BRIGHT_W = 3;
    localparam int COL_W    = 3;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int GRID_BITS  = 20;
    localparam int ANODE_BITS = 39;

    // Input item kinds as carried on tuser
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_COLUMN = 2'd1,
        MODE_BAR    = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Commands that survive classification
    typedef enum logic [1:0] {
        OP_TICK,
        OP_COLUMN,
        OP_BAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [BAR_W-1:0]  data;   // column byte in the low bits, or bar word
    } cmd_t;

    // Anode map for shift indices 20..58: {column, row}, dummy marks a spare pair
    localparam logic [5:0] ANODE_DUMMY = 6'o77;
    localparam logic [5:0] ANODE_MAP [ANODE_BITS] = '{
        6'o23, 6'o33, 6'o43, 6'o04, 6'o14, 6'o24, 6'o34,
        6'o44, 6'o05, 6'o15, 6'o25,
        6'o46, 6'o36, 6'o26, 6'o16, 6'o06,
        6'o77, 6'o77,
        6'o35, 6'o45,
        6'o77, 6'o77,
        6'o02, 6'o12, 6'o22, 6'o32, 6'o42, 6'o03, 6'o13,
        6'o41, 6'o31, 6'o21, 6'o11, 6'o01,
        6'o40, 6'o30, 6'o20, 6'o10, 6'o00
    };

    localparam logic [BLANK_W-1:0] BLANK_NEVER = 7'd80;

    // Shift index at which the clear line drops
    function automatic logic [BLANK_W-1:0] blank_index(input logic [BRIGHT_W-1:0] level);
        logic [BLANK_W-1:0] idx;
        unique case (level)
            3'd0, 3'd1: idx = 7'd0;
            3'd2:       idx = 7'd20;
            3'd3:       idx = 7'd38;
            3'd4:       idx = 7'd59;
            default:    idx = BLANK_NEVER;
        endcase
        return idx;
    endfunction

endpackage

[src/vfd_scan_serializer.sv]
`timescale 1ns / 1ps
// A scan tick goes through the command queue and the back end states ST_READ
// (five column reads through the single read port of the store), ST_DRAIN and
// ST_FORM; writes are applied in ST_IDLE, and no item is popped until a tick is done.
// Reset: synchronous, active low; the store reads as zero through per-entry
// valid bits, so no clearing pass is needed and items are taken right away.
// ----------------------------------------------------------------------------
// vfd_scan_serializer - multiplexed VFD refresh pattern generator
// APB brightness register, input classification, command queue and the
// scan back end producing one 80-bit shift pattern per tick.
// ----------------------------------------------------------------------------
module vfd_scan_serializer
    import vss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // column_address, column_pixels, bar_bits
    input  logic [1:0]          s_tuser,   // mode
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // scanned_position, first_shift_bits,
                                           // second_shift_bits, blank_from
);

    logic [BRIGHT_W-1:0] brightness_reg;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    cmd_t                q_cmd;
    cmd_t                q_head;
    logic [POS_W-1:0]    out_position;
    logic [SHIFT_W-1:0]  out_first;
    logic [SHIFT_W-1:0]  out_second;
    logic [BLANK_W-1:0]  out_blank;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(brightness_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_W'(5);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            brightness_reg <= pwdata[BRIGHT_W-1:0];
        end
    end

    vss_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    vss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    vss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .brightness   (brightness_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_position (out_position),
        .out_first    (out_first),
        .out_second   (out_second),
        .out_blank    (out_blank)
    );

    // Result packing, first field lowest
    assign m_tdata = {3'b000, out_blank, out_second, out_first, out_position};

endmodule

[src/vss_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_front - input side of the scan serializer
// Accepts input transfers, decodes the item kind, drops unused modes and
// out-of-range column writes, and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module vss_front
    import vss_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // column_address, column_pixels, bar_bits
    input  logic [1:0]          s_tuser,   // mode
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic              accept;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  pixels;
    logic [BAR_W-1:0]  bar;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Field unpacking
    assign addr   = s_tdata[ADDR_W-1:0];
    assign pixels = s_tdata[ADDR_W +: ROW_W];
    assign bar    = s_tdata[ADDR_W+ROW_W +: BAR_W];

    // Classification
    always_comb begin
        q_push     = 1'b0;
        q_cmd.op   = OP_TICK;
        q_cmd.addr = addr;
        q_cmd.data = BAR_W'(pixels);
        unique case (mode_t'(s_tuser))
            MODE_TICK: begin
                q_push = accept;
            end
            MODE_COLUMN: begin
                q_cmd.op = OP_COLUMN;
                q_push   = accept && (addr < ADDR_W'(STORE_DEPTH));
            end
            MODE_BAR: begin
                q_cmd.op   = OP_BAR;
                q_cmd.data = bar;
                q_push     = accept;
            end
            MODE_UNUSED: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

[src/vss_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_queue - command queue between front and back
// Small register FIFO; lets the input side keep taking items while the
// back end scans a position.
// ----------------------------------------------------------------------------
module vss_queue
    import vss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

[src/vss_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_back - execution side of the scan serializer
// Applies column and bar writes, and for a scan tick reads the five column
// bytes of the character, builds the 80-bit shift pattern and holds it in
// the output register.
// ----------------------------------------------------------------------------
module vss_back
    import vss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 q_head,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic [BRIGHT_W-1:0]  brightness,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [POS_W-1:0]     out_position,
    output logic [SHIFT_W-1:0]   out_first,
    output logic [SHIFT_W-1:0]   out_second,
    output logic [BLANK_W-1:0]   out_blank
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FORM
    } state_t;

    state_t             state_reg;
    logic [COL_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [POS_W-1:0]   scan_pos_reg;
    logic [BAR_W-1:0]   bar_reg;
    logic               m_tvalid_reg;
    logic [POS_W-1:0]   pos_out_reg;
    logic [SHIFT_W-1:0] first_out_reg;
    logic [SHIFT_W-1:0] second_out_reg;
    logic [BLANK_W-1:0] blank_out_reg;

    // Pixel memory with per-entry valid bits (unwritten entries read zero)
    logic [ROW_W-1:0]   mem [STORE_DEPTH];
    logic               valid_reg [STORE_DEPTH];
    logic [ROW_W-1:0]   rd_data_reg;
    logic               rd_vld_reg;
    logic               cap_en_reg;
    logic [COL_W-1:0]   cap_idx_reg;
    logic [ROW_W-1:0]   col_reg [COLUMNS_PER_CHAR];

    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               out_free;
    logic               out_load;
    logic [POS_W-1:0]   q;
    logic [SHIFT_W-1:0] first_w;
    logic [SHIFT_W-1:0] second_w;
    logic               bar_bit;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we   = q_pop && (q_head.op == OP_COLUMN);
    assign rd_en    = (state_reg == ST_READ);
    assign rd_addr  = base_reg + ADDR_W'(cnt_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_FORM) && out_free;

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_head.addr] <= q_head.data[ROW_W-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits and read capture control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
            rd_vld_reg  <= 1'b0;
            cap_en_reg  <= 1'b0;
            cap_idx_reg <= '0;
        end else begin
            if (mem_we) begin
                valid_reg[q_head.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            cap_en_reg  <= rd_en;
            cap_idx_reg <= cnt_reg;
        end
    end

    // Column bytes of the character being scanned
    always_ff @(posedge aclk) begin
        if (cap_en_reg) begin
            col_reg[cap_idx_reg] <= rd_vld_reg ? rd_data_reg : '0;
        end
    end

    // Grid position remap
    always_comb begin
        priority if (scan_pos_reg >= POS_W'(10) && scan_pos_reg <= POS_W'(19)) begin
            q = scan_pos_reg + POS_W'(20);
        end else if (scan_pos_reg >= POS_W'(20)) begin
            q = scan_pos_reg - POS_W'(10);
        end else begin
            q = scan_pos_reg;
        end
    end

    // Shift pattern
    always_comb begin
        first_w  = '0;
        second_w = '0;
        bar_bit  = 1'b0;
        // lower grid, g7..g1 then g8..g20
        priority if (q < POS_W'(7)) begin
            first_w = SHIFT_W'(1) << (POS_W'(6) - q);
        end else if (q < POS_W'(GRID_BITS)) begin
            first_w = SHIFT_W'(1) << q;
        end else if (q < POS_W'(33)) begin
            // upper grid g21..g33 lands at second bit 20+(q-20)
            second_w = SHIFT_W'(1) << q;
        end else begin
            // upper grid g40..g34 lands at second bit 72-q
            second_w = SHIFT_W'(1) << (7'd72 - {1'b0, q});
        end
        // anode pixels
        for (int i = 0; i < ANODE_BITS; i++) begin
            if (ANODE_MAP[i] != ANODE_DUMMY) begin
                if (i + GRID_BITS < SHIFT_W) begin
                    first_w[i+GRID_BITS] = col_reg[ANODE_MAP[i][5:3]][ANODE_MAP[i][2:0]];
                end else begin
                    second_w[i+GRID_BITS-SHIFT_W] =
                        col_reg[ANODE_MAP[i][5:3]][ANODE_MAP[i][2:0]];
                end
            end
        end
        // upper bar
        priority if (q < POS_W'(10)) begin
            bar_bit = bar_reg[q[4:0]];
        end else if (q >= POS_W'(30) && q < POS_W'(CHARACTERS)) begin
            bar_bit = bar_reg[5'(q - POS_W'(20))];
        end else begin
            bar_bit = 1'b0;
        end
        second_w[19] = bar_bit;
    end

    // Sequencer, scan state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            scan_pos_reg <= '0;
            bar_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        unique case (q_head.op)
                            OP_TICK: begin
                                base_reg  <= (ADDR_W'(scan_pos_reg) << 2)
                                             + ADDR_W'(scan_pos_reg);
                                cnt_reg   <= '0;
                                state_reg <= ST_READ;
                            end
                            OP_BAR: begin
                                bar_reg <= q_head.data;
                            end
                            default: begin
                                // column write handled by the memory port
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    if (cnt_reg == COL_W'(COLUMNS_PER_CHAR - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FORM;
                end
                ST_FORM: begin
                    if (out_free) begin
                        pos_out_reg    <= scan_pos_reg;
                        first_out_reg  <= first_w;
                        second_out_reg <= second_w;
                        blank_out_reg  <= blank_index(brightness);
                        scan_pos_reg   <= (scan_pos_reg >= POS_W'(CHARACTERS - 1))
                                          ? '0 : scan_pos_reg + 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign out_position = pos_out_reg;
    assign out_first    = first_out_reg;
    assign out_second   = second_out_reg;
    assign out_blank    = blank_out_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> cnt_reg < COL_W'(COLUMNS_PER_CHAR))
        else $error("column counter out of range");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_pos_reg < POS_W'(CHARACTERS))
        else $error("scan position out of range");

    a_grid_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |->
            ($countones(first_out_reg[GRID_BITS-1:0])
             + $countones(second_out_reg[SHIFT_W-1:GRID_BITS])) == 1)
        else $error("grid pattern not one-hot");

    a_blank_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (blank_out_reg == 7'd0 || blank_out_reg == 7'd20
                          || blank_out_reg == 7'd38 || blank_out_reg == 7'd59
                          || blank_out_reg == BLANK_NEVER))
        else $error("blanking index not a legal level");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_IDLE && q_head.addr < ADDR_W'(STORE_DEPTH))
        else $error("pixel write outside idle or store range");
`endif

endmodule
